// ===== rtl/grr_pkg.sv =====
// ============================================================================
// grr_pkg : shared types and constants for the group reverse reorder block
// Widths, register map, controller states and the chain control bundle.
// ============================================================================
package grr_pkg;

    localparam int GRR_DATA_W        = 32;
    localparam int GRR_CFG_W         = 6;
    localparam int GRR_GROUP_MAX_DEF = 32;
    localparam int GRR_PADDR_W       = 3;
    localparam int GRR_PDATA_W       = 32;

    // register index (word address)
    localparam logic REG_GROUP_SIZE = 1'b0;

    localparam logic [GRR_CFG_W-1:0] GRR_GROUP_SIZE_RST = 6'd1;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_REV,
        ST_FWD
    } t_state;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_RIGHT,
        SH_LEFT
    } t_shift;

    typedef struct packed {
        t_shift shift;
        logic   tail_sel;
    } t_chain_ctl;

endpackage

// ===== rtl/grr_cell.sv =====
// ============================================================================
// grr_cell : one storage cell of the reorder chain
// Holds one element; loads from its left or right neighbor or holds.
// ============================================================================
module grr_cell (
    input  logic                            i_clk,
    input  grr_pkg::t_chain_ctl             i_ctl,
    input  logic [grr_pkg::GRR_DATA_W-1:0]  i_from_left,
    input  logic [grr_pkg::GRR_DATA_W-1:0]  i_from_right,
    output logic [grr_pkg::GRR_DATA_W-1:0]  o_value
);
    import grr_pkg::*;

    logic [GRR_DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_ctl.shift)
            SH_RIGHT: r_value <= i_from_left;
            SH_LEFT:  r_value <= i_from_right;
            default:  r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

// ===== rtl/grr_ctrl.sv =====
// ============================================================================
// grr_ctrl : fill / drain sequencer for the reorder chain
// Counts buffered elements and steps the chain through a flush.
// ============================================================================
module grr_ctrl #(
    parameter int GROUP_MAX = grr_pkg::GRR_GROUP_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [grr_pkg::GRR_CFG_W-1:0]   i_group_size,
    input  logic                            i_in_valid,
    input  logic                            i_list_end,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_run_last,
    output logic                            o_out_list_end,
    output grr_pkg::t_chain_ctl             o_ctl
);
    import grr_pkg::*;

    localparam int CW = $clog2(GROUP_MAX + 1);
    localparam int SW = (CW > GRR_CFG_W) ? CW : GRR_CFG_W;
    localparam logic [CW-1:0] GM  = CW'(GROUP_MAX);
    localparam logic [SW-1:0] GMS = SW'(GROUP_MAX);
    localparam logic [CW-1:0] ONE = CW'(1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_step, n_step;
    logic [CW-1:0] r_n, n_n;
    logic          r_last, n_last;

    logic [SW-1:0] w_gs;
    logic [CW-1:0] w_k;
    logic [CW-1:0] w_fill_inc;
    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_final;
    logic          w_fwd_show;

    // effective group size: zero acts as one, large values saturate
    assign w_gs = SW'(i_group_size);
    always_comb begin
        if (w_gs == '0) begin
            w_k = ONE;
        end else if (w_gs > GMS) begin
            w_k = GM;
        end else begin
            w_k = w_gs[CW-1:0];
        end
    end

    assign w_fill_inc = r_fill + ONE;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_acc  = o_out_valid & ~i_out_stall;
    assign w_fwd_show = (r_step >= (GM - r_n));

    // outputs
    always_comb begin
        o_in_stall   = 1'b1;
        o_out_valid  = 1'b0;
        w_final      = 1'b0;
        o_ctl.shift  = SH_HOLD;
        o_ctl.tail_sel = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                o_in_stall  = 1'b0;
                o_ctl.shift = i_in_valid ? SH_RIGHT : SH_HOLD;
            end
            ST_REV: begin
                o_out_valid = 1'b1;
                w_final     = (r_step == (r_n - ONE));
                o_ctl.shift = i_out_stall ? SH_HOLD : SH_LEFT;
            end
            ST_FWD: begin
                o_out_valid    = w_fwd_show;
                w_final        = (r_step == (GM - ONE));
                o_ctl.tail_sel = 1'b1;
                o_ctl.shift    = (!w_fwd_show || !i_out_stall) ? SH_RIGHT : SH_HOLD;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_run_last     = w_final;
    assign o_out_list_end = w_final & r_last;

    // next state
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_step  = r_step;
        n_n     = r_n;
        n_last  = r_last;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc) begin
                    if (w_fill_inc >= w_k) begin
                        n_state = ST_REV;
                        n_n     = w_fill_inc;
                        n_step  = '0;
                        n_fill  = '0;
                        n_last  = i_list_end;
                    end else if (i_list_end) begin
                        n_state = ST_FWD;
                        n_n     = w_fill_inc;
                        n_step  = '0;
                        n_fill  = '0;
                        n_last  = 1'b1;
                    end else begin
                        n_fill  = w_fill_inc;
                    end
                end
            end
            ST_REV: begin
                if (w_out_acc) begin
                    n_step = r_step + ONE;
                    if (w_final) begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FWD: begin
                if (!w_fwd_show || w_out_acc) begin
                    n_step = r_step + ONE;
                end
                if (w_out_acc && w_final) begin
                    n_state = ST_FILL;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
        r_step <= n_step;
        r_n    <= n_n;
        r_last <= n_last;
    end

    // checks
    a_rev_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REV) |-> (r_step < r_n))
        else $error("reverse drain step past group length");

    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> (r_fill < GM))
        else $error("fill count reached buffer depth while filling");

    a_final_returns_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_final) |=> (r_state == ST_FILL))
        else $error("flush did not end after its last request");

    a_quiet_on_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_fill_inc < w_k) && !i_list_end) |=> !o_out_valid)
        else $error("output raised by a request that completes no group");

    a_fwd_end_at_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FWD) |-> (r_step < GM))
        else $error("forward drain step past chain end");

endmodule

// ===== rtl/group_reverse_reorder.sv =====
// ============================================================================
// group_reverse_reorder : streamed list reversal in groups of k elements
// A chain of cells buffers each group; full groups leave newest first, a
// partial group at list end leaves in arrival order.
// ============================================================================
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  ----------------------------------
//  input     in   i_in_valid / o_in_stall   i_element_value, i_list_end
//  output    out  o_out_valid / i_out_stall o_out_value, o_run_last,
//                                           o_out_list_end
//  config    in   APB (psel/penable/...)    group_size at byte address 0
//
//  Flow: a request that completes no group is taken and leaves the input open. A
//  full group of k requests fills the chain, then the chain shifts one cell per
//  cycle while i_out_stall is low to deliver k results. A partial group of n at
//  list end holds the input off while the chain walks its oldest element to
//  the far cell one position a cycle, pausing only while a shown result is
//  stalled, and the n results leave in the last n of those steps.
//  Reset: synchronous, active low; clears controller state and group_size to 1.
//  Stalls: o_in_stall is high for the whole flush; i_out_stall freezes the
//  chain while a result is presented, so it holds until taken.
//
module group_reverse_reorder #(
    parameter int GROUP_MAX = grr_pkg::GRR_GROUP_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [grr_pkg::GRR_DATA_W-1:0] i_element_value,
    input  logic                              i_list_end,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [grr_pkg::GRR_DATA_W-1:0] o_out_value,
    output logic                              o_run_last,
    output logic                              o_out_list_end,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [grr_pkg::GRR_PADDR_W-1:0]   paddr,
    input  logic [grr_pkg::GRR_PDATA_W-1:0]   pwdata,
    output logic [grr_pkg::GRR_PDATA_W-1:0]   prdata,
    output logic                              pready
);
    import grr_pkg::*;

    logic [GRR_CFG_W-1:0]  r_group_size;
    logic                  w_reg_sel;
    logic                  w_cfg_wr;
    t_chain_ctl            w_ctl;
    logic [GRR_DATA_W-1:0] w_cell [GROUP_MAX];

    // ---------------------------------------------------------------------
    // configuration register: word index is paddr[2]
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == REG_GROUP_SIZE);
    assign w_cfg_wr  = psel & penable & pwrite & w_reg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GRR_GROUP_SIZE_RST;
        end else if (w_cfg_wr) begin
            r_group_size <= pwdata[GRR_CFG_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? GRR_PDATA_W'(r_group_size) : '0;

    // ---------------------------------------------------------------------
    // sequencer: counts the group, then steps the chain through a flush
    // ---------------------------------------------------------------------
    grr_ctrl #(
        .GROUP_MAX (GROUP_MAX)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_group_size   (r_group_size),
        .i_in_valid     (i_in_valid),
        .i_list_end     (i_list_end),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_run_last     (o_run_last),
        .o_out_list_end (o_out_list_end),
        .o_ctl          (w_ctl)
    );

    // ---------------------------------------------------------------------
    // cell chain: a new element enters cell 0 and pushes the rest right,
    // so cell 0 holds the newest element while filling. Shifting left pops newest
    // first from cell 0 (reverse); shifting right walks the oldest element
    // to the last cell (arrival order).
    // ---------------------------------------------------------------------
    for (genvar j = 0; j < GROUP_MAX; j++) begin : g_cell
        logic [GRR_DATA_W-1:0] w_left;
        logic [GRR_DATA_W-1:0] w_right;

        if (j == 0) begin : g_head
            assign w_left = i_element_value;
        end else begin : g_mid_l
            assign w_left = w_cell[j-1];
        end

        if (j == GROUP_MAX - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[j+1];
        end

        grr_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_from_left  (w_left),
            .i_from_right (w_right),
            .o_value      (w_cell[j])
        );
    end

    // result taken from the tail in forward drain, from the head otherwise
    assign o_out_value = w_ctl.tail_sel ? w_cell[GROUP_MAX-1] : w_cell[0];

endmodule
